@@ src/ptg_pkg.sv @@
// Shared widths, defaults and divider request type for the periodic trigger generator.
`default_nettype none
package ptg_pkg;
    localparam int CHANNELS_DEF = 8;
    localparam int CH_W         = 3;
    localparam int SMP_W        = 24;
    localparam int CNT_W        = 32;
    localparam int DVD_W        = CNT_W + 1;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 40;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [SMP_W-1:0] divisor;
    } t_div_req;
endpackage
`default_nettype wire

@@ src/ptg_rem.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module ptg_rem
    import ptg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic                  o_done,
    output logic [SMP_W-1:0]      o_rem
);
    localparam int STEPS = DVD_W;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_dvd;
    logic [SMP_W-1:0]  r_div;
    logic [SMP_W-1:0]  r_rem;
    logic [SMP_W:0]    w_trial;
    logic [SMP_W:0]    w_diff;
    logic              w_fits;

    // shift in the next dividend bit, subtract where the divisor fits
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(STEPS);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_fits ? w_diff[SMP_W-1:0] : w_trial[SMP_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

@@ src/periodic_trigger_generator_core.sv @@
// Periodic trigger generator: per-channel period counters with phase delay and wrap.
// An input transfer is taken in S_IDLE; the item then passes through S_PREP and
//   S_FIN, with S_DIV between them when the counter wraps and its remainder has to
//   be worked out by the 33-step bit-serial remainder unit. S_FIN loads the result
//   once the output is free; no new input transfer is taken before that.
// Reset (i_rst_n low, synchronous): all channel counters read as zero, no result pending.
`default_nettype none
module periodic_trigger_generator_core
    import ptg_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // [0] reset_req, [24:1] interval_samples, [48:25] delay_samples, [55:49] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [2:0] channel
    input  wire logic [CH_W-1:0]        i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [0] pulse, [32:1] elapsed_samples, [39:33] zero
    output logic [OUT_TDATA_W-1:0]      o_m_tdata
);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;

    // counter store, one entry per channel; entries not yet written read as zero
    logic [CNT_W-1:0]       r_mem [CHANNELS];
    logic [CHANNELS-1:0]    r_valid;
    logic [CNT_W-1:0]       r_rd;
    logic                   r_rd_vld;

    // item held while it is worked on
    logic [IDX_W-1:0]       r_idx;
    logic                   r_restart;
    logic [SMP_W-1:0]       r_mag;
    logic [SMP_W-1:0]       r_delay;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;

    logic                   r_o_valid;
    logic [OUT_TDATA_W-1:0] r_o_data;

    logic                   w_take;
    logic [IDX_W-1:0]       w_idx;
    logic [SMP_W-1:0]       w_interval;
    logic [SMP_W-1:0]       w_mag;
    logic [CNT_W-1:0]       w_cur;
    logic [CNT_W+1:0]       w_delayed;
    logic                   w_wraps;
    logic [SMP_W+1:0]       w_wrap;
    logic [CNT_W-1:0]       w_inc;
    logic                   w_out_free;
    t_div_req               w_div_req;
    logic                   w_div_done;
    logic [SMP_W-1:0]       w_rem;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_take     = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_o_valid || i_m_tready;

    // fold the channel number onto the channels present
    always_comb begin
        logic [6:0] v;
        v = {{(7-CH_W){1'b0}}, i_s_tuser};
        for (int i = 0; i < 7; i++) begin
            if (v >= 7'(CHANNELS)) begin
                v = v - 7'(CHANNELS);
            end
        end
        w_idx = IDX_W'(v);
    end

    // magnitude of the interval; the most negative value still fits unsigned
    assign w_interval = i_s_tdata[SMP_W:1];
    assign w_mag      = w_interval[SMP_W-1] ? (~w_interval + 1'b1) : w_interval;

    // counter minus delay, signed over 34 bits
    assign w_cur     = r_rd_vld ? r_rd : '0;
    assign w_delayed = {2'b00, w_cur} - {{(CNT_W+2-SMP_W){r_delay[SMP_W-1]}}, r_delay};
    assign w_wraps   = !w_delayed[CNT_W+1] &&
                       (w_delayed[CNT_W:0] >= {{(DVD_W-SMP_W){1'b0}}, r_mag});

    // after the wrap the counter is delay plus remainder, held at zero below
    assign w_wrap = {{2{r_delay[SMP_W-1]}}, r_delay} + {2'b00, w_rem};

    assign w_inc = (r_cnt == {CNT_W{1'b1}}) ? r_cnt : r_cnt + 1'b1;

    assign w_div_req.start    = (r_state == S_PREP) && !r_restart && w_wraps;
    assign w_div_req.dividend = w_delayed[CNT_W:0];
    assign w_div_req.divisor  = r_mag;

    ptg_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_restart) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end else if (w_wraps) begin
                    n_state = S_DIV;
                end else begin
                    n_cnt   = w_cur;
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_cnt   = w_wrap[SMP_W+1] ? '0
                                              : {{(CNT_W-SMP_W-1){1'b0}}, w_wrap[SMP_W:0]};
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && w_out_free) begin
                r_valid[r_idx] <= 1'b1;
                r_o_valid      <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // counter store: read on the input transfer, write back the advanced count
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rd     <= r_mem[w_idx];
            r_rd_vld <= r_valid[w_idx];
        end
        if (r_state == S_FIN && w_out_free) begin
            r_mem[r_idx] <= w_inc;
        end
    end

    // payload: latch the item, hold the count, load the result register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx     <= w_idx;
            r_restart <= i_s_tdata[0] || (w_interval == '0);
            r_mag     <= w_mag;
            r_delay   <= i_s_tdata[2*SMP_W:SMP_W+1];
        end
        r_cnt <= n_cnt;
        if (r_state == S_FIN && w_out_free) begin
            r_o_data <= {{(OUT_TDATA_W-CNT_W-1){1'b0}}, r_cnt, (r_cnt == '0)};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

`ifndef NO_ASSERTIONS
    // an input transfer always starts the work of that item
    a_take_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_state == S_PREP))
        else $error("input transfer did not start the item");

    // the remainder unit finishes only while the sequencer waits for it
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("remainder finished outside the wrap step");

    // the pulse flag matches a zero elapsed count
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tdata[CNT_W:1] == '0)))
        else $error("pulse disagrees with elapsed count");

    // a wrapped counter has no bits set above bit SMP_W
    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_div_done) |=> (r_cnt[CNT_W-1:SMP_W+1] == '0))
        else $error("wrapped counter out of range");
`endif
endmodule
`default_nettype wire
